// ===== design/mjq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers for the minimum-jerk quintic solver.
// No dependencies; mjq_div and the top level import this package.
package mjq_pkg;

   localparam int FracBitsDefault = 16;
   localparam int OutFrac         = 32;
   localparam int InW             = 32;
   localparam int DurW            = 31;
   localparam int CoefW           = 48;
   localparam int ChunkW          = DurW;
   localparam int PpW             = 2 * DurW;
   localparam int D3W             = 3 * DurW;
   localparam int D4W             = 4 * DurW;
   localparam int DenW            = 5 * DurW;
   // numerator terms fit for every FRAC_BITS up to 24
   localparam int ProdW           = 100;
   localparam int B2W             = 66;
   localparam int DivLat          = CoefW + 2;

   localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
   localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DUR = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [InW-1:0] start_position;
      logic signed [InW-1:0] start_velocity;
      logic signed [InW-1:0] start_accel;
      logic signed [InW-1:0] end_position;
      logic signed [InW-1:0] end_velocity;
      logic signed [InW-1:0] end_accel;
      logic [DurW-1:0]       duration;
   } req_type;

   typedef struct packed {
      logic signed [CoefW-1:0] coef0;
      logic signed [CoefW-1:0] coef1;
      logic signed [CoefW-1:0] coef2;
      logic signed [CoefW-1:0] coef3;
      logic signed [CoefW-1:0] coef4;
      logic signed [CoefW-1:0] coef5;
      logic [1:0]              status;
   } rsp_type;

   function automatic logic fits48(input logic [63:0] v);
      return (v[63:CoefW-1] == '0) || (v[63:CoefW-1] == '1);
   endfunction

   function automatic logic [CoefW-1:0] sat48(input logic [63:0] v);
      if (fits48(v)) begin
         return v[CoefW-1:0];
      end
      return v[63] ? CoefMin : CoefMax;
   endfunction

endpackage

// ===== design/mjq_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is given at instantiation, normally from mjq_pkg.
interface mjq_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mjq_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, 48-bit saturating result.
// Depends on mjq_pkg for the coefficient width and limits.
module mjq_div
   import mjq_pkg::*;
#(
   parameter int NUM_W = ProdW + OutFrac - 1 + 2 * FracBitsDefault,
   parameter int DEN_W = DenW
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [NUM_W-1:0]        num_mag,
   input  logic                    num_neg,
   input  logic [DEN_W-1:0]        den,
   output logic signed [CoefW-1:0] quo,
   output logic                    sat
);

   localparam int HighW = NUM_W - CoefW;
   localparam int CmpW  = (HighW > DEN_W) ? HighW : DEN_W;

   typedef struct packed {
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [CoefW-1:0] low;
      logic [CoefW-1:0] quo;
      logic             ovf;
      logic             neg;
   } step_type;

   step_type step_ff [CoefW+1];
   step_type step_in [CoefW+1];

   logic signed [CoefW-1:0] quo_ff, quo_in;
   logic                    sat_ff, sat_in;

   // entry: quotient overflows 48 bits exactly when the upper part reaches the divisor
   always_comb begin
      step_in[0].den = den;
      step_in[0].ovf = CmpW'(num_mag[NUM_W-1:CoefW]) >= CmpW'(den);
      step_in[0].rem = DEN_W'(num_mag[NUM_W-1:CoefW]);
      step_in[0].low = num_mag[CoefW-1:0];
      step_in[0].quo = '0;
      step_in[0].neg = num_neg;
   end

   for (genvar k = 1; k <= CoefW; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           take;
      always_comb begin
         trial = {step_ff[k-1].rem, step_ff[k-1].low[CoefW-1]};
         take  = trial >= {1'b0, step_ff[k-1].den};
         step_in[k]     = step_ff[k-1];
         step_in[k].rem = take ? DEN_W'(trial - {1'b0, step_ff[k-1].den}) : DEN_W'(trial);
         step_in[k].low = step_ff[k-1].low << 1;
         step_in[k].quo = {step_ff[k-1].quo[CoefW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CoefW; k++) begin
            step_ff[k] <= step_in[k];
         end
      end
   end

   // apply sign and clamp
   always_comb begin
      quo_in = '0;
      sat_in = 1'b0;
      if (step_ff[CoefW].ovf) begin
         sat_in = 1'b1;
         quo_in = step_ff[CoefW].neg ? CoefMin : CoefMax;
      end else if (step_ff[CoefW].neg) begin
         if (step_ff[CoefW].quo[CoefW-1] && (|step_ff[CoefW].quo[CoefW-2:0])) begin
            sat_in = 1'b1;
            quo_in = CoefMin;
         end else begin
            quo_in = -step_ff[CoefW].quo;
         end
      end else if (step_ff[CoefW].quo[CoefW-1]) begin
         sat_in = 1'b1;
         quo_in = CoefMax;
      end else begin
         quo_in = step_ff[CoefW].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
         sat_ff <= sat_in;
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

// ===== design/min_jerk_quintic_solver.sv =====
`timescale 1ns / 1ps
// Top level of the minimum-jerk quintic solver: boundary terms, powers of T,
// numerators and three pipelined dividers. Depends on mjq_pkg, mjq_chan_if, mjq_div.
//
// Usage
//   req_if carries one axis per transaction: start and end position, velocity,
//   acceleration (signed, FRAC_BITS fraction bits) and the duration T.
//   rsp_if returns the six quintic coefficients in signed Q16.32 and a status:
//   ok, zero duration (coef3..coef5 forced to zero) or saturated.
//   Throughput: one transaction per cycle, sustained while rsp_if.ready stays high.
//   Pipeline from acceptance to rsp_if.valid: seven stages build
//   T^2..T^5 from 31x31 partial products and the numerators, 50 stages of
//   the restoring dividers (entry check, one quotient bit per step, sign), one output register.
//   Stall: the whole pipeline advances as one; while a result waits on
//   rsp_if.ready every stage holds and req_if.ready drops, so nothing is lost
//   or repeated. req_if.ready stays high whenever the output register is free
//   or being emptied.
//   Reset: synchronous, clears every valid bit; no clearing pass, the block
//   accepts transactions in the first cycle after reset.
module min_jerk_quintic_solver
   import mjq_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input logic        clock,
   input logic        reset,
   mjq_chan_if.sink   req_if,
   mjq_chan_if.source rsp_if
);

   localparam int NumW = ProdW + OutFrac - 1 + 2 * FRAC_BITS;
   localparam int Sh3  = OutFrac - 1;
   localparam int Sh4  = OutFrac - 1 + FRAC_BITS;
   localparam int Sh5  = OutFrac - 1 + 2 * FRAC_BITS;

   // bookkeeping that rides along with every transaction
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic             sat;
      logic [CoefW-1:0] c0;
      logic [CoefW-1:0] c1;
      logic [CoefW-1:0] c2;
   } side_type;

   typedef struct packed {
      side_type        side;
      logic [InW:0]    dp;
      logic [InW:0]    dv;
      logic [InW:0]    da;
      logic [DurW-1:0] dur;
      logic [PpW-1:0]  d2;
      logic [63:0]     v0d;
      logic [63:0]     a0d;
   } s1_type;

   typedef struct packed {
      side_type         side;
      logic [DurW-1:0]  dur;
      logic [PpW-1:0]   d3_lo;
      logic [PpW-1:0]   d3_hi;
      logic [PpW-1:0]   a0d2_lo;
      logic [65:0]      a0d2_hi;
      logic [65:0]      dad2_lo;
      logic [65:0]      dad2_hi;
      logic [ProdW-1:0] b1a;
      logic [B2W-1:0]   b2;
   } s2_type;

   typedef struct packed {
      side_type         side;
      logic [DurW-1:0]  dur;
      logic [D3W-1:0]   d3;
      logic [ProdW-1:0] a0d2;
      logic [ProdW-1:0] dad2;
      logic [ProdW-1:0] b1a;
      logic [PpW-1:0]   b2d_lo;
      logic [67:0]      b2d_hi;
   } s3_type;

   typedef struct packed {
      side_type         side;
      logic [DurW-1:0]  dur;
      logic [D3W-1:0]   d3;
      logic [PpW-1:0]   d4_p0;
      logic [PpW-1:0]   d4_p1;
      logic [PpW-1:0]   d4_p2;
      logic [ProdW-1:0] b1;
      logic [ProdW-1:0] b2d;
      logic [ProdW-1:0] dad2;
   } s4_type;

   typedef struct packed {
      side_type         side;
      logic [DurW-1:0]  dur;
      logic [D3W-1:0]   d3;
      logic [D4W-1:0]   d4;
      logic [ProdW-1:0] x3;
      logic [ProdW-1:0] x4;
      logic [ProdW-1:0] x5;
      logic [ProdW-1:0] dad2;
   } s5_type;

   typedef struct packed {
      side_type         side;
      logic [D3W-1:0]   d3;
      logic [D4W-1:0]   d4;
      logic [PpW-1:0]   d5_p0;
      logic [PpW-1:0]   d5_p1;
      logic [PpW-1:0]   d5_p2;
      logic [PpW-1:0]   d5_p3;
      logic [ProdW-1:0] n3;
      logic [ProdW-1:0] n4;
      logic [ProdW-1:0] n5;
   } s6_type;

   typedef struct packed {
      side_type         side;
      logic [D3W-1:0]   d3;
      logic [D4W-1:0]   d4;
      logic [DenW-1:0]  d5;
      logic [ProdW-1:0] mag3;
      logic [ProdW-1:0] mag4;
      logic [ProdW-1:0] mag5;
      logic             neg3;
      logic             neg4;
      logic             neg5;
   } s7_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;

   side_type side_ff [DivLat];

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   logic                    adv;
   logic signed [CoefW-1:0] q3, q4, q5;
   logic                    sat3, sat4, sat5;

   // advance everything together unless a finished result is held back
   assign adv          = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;

   // stage 1: differences, T^2, v0*T, a0*T and the three exact coefficients
   always_comb begin
      logic [63:0] c0_w;
      logic [63:0] c1_w;
      logic [63:0] c2_w;
      c0_w = 64'($signed(req_if.payload.start_position)) <<< (OutFrac - FRAC_BITS);
      c1_w = 64'($signed(req_if.payload.start_velocity)) <<< (OutFrac - FRAC_BITS);
      c2_w = 64'($signed(req_if.payload.start_accel)) <<< (OutFrac - 1 - FRAC_BITS);
      s1_in.side.valid = req_if.valid;
      s1_in.side.zero  = req_if.payload.duration == '0;
      s1_in.side.sat   = !fits48(c0_w) || !fits48(c1_w) || !fits48(c2_w);
      s1_in.side.c0    = sat48(c0_w);
      s1_in.side.c1    = sat48(c1_w);
      s1_in.side.c2    = sat48(c2_w);
      s1_in.dp  = 33'($signed(req_if.payload.end_position))
                - 33'($signed(req_if.payload.start_position));
      s1_in.dv  = 33'($signed(req_if.payload.end_velocity))
                - 33'($signed(req_if.payload.start_velocity));
      s1_in.da  = 33'($signed(req_if.payload.end_accel))
                - 33'($signed(req_if.payload.start_accel));
      s1_in.dur = req_if.payload.duration;
      s1_in.d2  = PpW'(req_if.payload.duration) * PpW'(req_if.payload.duration);
      s1_in.v0d = 64'($signed(req_if.payload.start_velocity))
                * 64'($signed({1'b0, req_if.payload.duration}));
      s1_in.a0d = 64'($signed(req_if.payload.start_accel))
                * 64'($signed({1'b0, req_if.payload.duration}));
   end

   // stage 2: partial products of T^3, a0*T^2, da*T^2; first part of b1, all of b2
   always_comb begin
      s2_in.side    = s1_ff.side;
      s2_in.dur     = s1_ff.dur;
      s2_in.d3_lo   = PpW'(s1_ff.d2[ChunkW-1:0]) * PpW'(s1_ff.dur);
      s2_in.d3_hi   = PpW'(s1_ff.d2[PpW-1:ChunkW]) * PpW'(s1_ff.dur);
      s2_in.a0d2_lo = PpW'(s1_ff.a0d[ChunkW-1:0]) * PpW'(s1_ff.dur);
      s2_in.a0d2_hi = 66'($signed(s1_ff.a0d[63:ChunkW])) * 66'($signed({1'b0, s1_ff.dur}));
      s2_in.dad2_lo = 66'($signed(s1_ff.da))
                    * 66'($signed({1'b0, s1_ff.d2[ChunkW-1:0]}));
      s2_in.dad2_hi = 66'($signed(s1_ff.da))
                    * 66'($signed({1'b0, s1_ff.d2[PpW-1:ChunkW]}));
      s2_in.b1a = (ProdW'($signed(s1_ff.dp)) <<< (2 * FRAC_BITS + 1))
                - (ProdW'($signed(s1_ff.v0d)) <<< (FRAC_BITS + 1));
      s2_in.b2  = (B2W'($signed(s1_ff.dv)) <<< FRAC_BITS) - B2W'($signed(s1_ff.a0d));
   end

   // stage 3: gather partial products; split b2*T
   always_comb begin
      s3_in.side   = s2_ff.side;
      s3_in.dur    = s2_ff.dur;
      s3_in.b1a    = s2_ff.b1a;
      s3_in.d3     = D3W'(s2_ff.d3_lo) + (D3W'(s2_ff.d3_hi) << ChunkW);
      s3_in.a0d2   = (ProdW'($signed(s2_ff.a0d2_hi)) << ChunkW) + ProdW'(s2_ff.a0d2_lo);
      s3_in.dad2   = (ProdW'($signed(s2_ff.dad2_hi)) << ChunkW)
                   + ProdW'($signed(s2_ff.dad2_lo));
      s3_in.b2d_lo = PpW'(s2_ff.b2[ChunkW-1:0]) * PpW'(s2_ff.dur);
      s3_in.b2d_hi = 68'($signed(s2_ff.b2[B2W-1:ChunkW])) * 68'($signed({1'b0, s2_ff.dur}));
   end

   // stage 4: finish b1 and b2*T; partial products of T^4
   always_comb begin
      s4_in.side  = s3_ff.side;
      s4_in.dur   = s3_ff.dur;
      s4_in.d3    = s3_ff.d3;
      s4_in.dad2  = s3_ff.dad2;
      s4_in.b1    = s3_ff.b1a - s3_ff.a0d2;
      s4_in.b2d   = (ProdW'($signed(s3_ff.b2d_hi)) << ChunkW) + ProdW'(s3_ff.b2d_lo);
      s4_in.d4_p0 = PpW'(s3_ff.d3[ChunkW-1:0]) * PpW'(s3_ff.dur);
      s4_in.d4_p1 = PpW'(s3_ff.d3[2*ChunkW-1:ChunkW]) * PpW'(s3_ff.dur);
      s4_in.d4_p2 = PpW'(s3_ff.d3[D3W-1:2*ChunkW]) * PpW'(s3_ff.dur);
   end

   // stage 5: T^4; weighted sums of b1 and b2*T (shift and add only)
   always_comb begin
      logic signed [ProdW-1:0] b1;
      logic signed [ProdW-1:0] b2d;
      b1  = $signed(s4_ff.b1);
      b2d = $signed(s4_ff.b2d);
      s5_in.side = s4_ff.side;
      s5_in.dur  = s4_ff.dur;
      s5_in.d3   = s4_ff.d3;
      s5_in.dad2 = s4_ff.dad2;
      s5_in.d4   = D4W'(s4_ff.d4_p0) + (D4W'(s4_ff.d4_p1) << ChunkW)
                 + (D4W'(s4_ff.d4_p2) << (2 * ChunkW));
      s5_in.x3   = (b1 <<< 3) + (b1 <<< 1) - (b2d <<< 3);
      s5_in.x4   = (b2d <<< 4) - (b2d <<< 1) - (b1 <<< 4) + b1;
      s5_in.x5   = (b1 <<< 2) + (b1 <<< 1) - (b2d <<< 2) - (b2d <<< 1);
   end

   // stage 6: add the acceleration term; partial products of T^5
   always_comb begin
      s6_in.side  = s5_ff.side;
      s6_in.d3    = s5_ff.d3;
      s6_in.d4    = s5_ff.d4;
      s6_in.n3    = s5_ff.x3 + s5_ff.dad2;
      s6_in.n4    = s5_ff.x4 - (s5_ff.dad2 << 1);
      s6_in.n5    = s5_ff.x5 + s5_ff.dad2;
      s6_in.d5_p0 = PpW'(s5_ff.d4[ChunkW-1:0]) * PpW'(s5_ff.dur);
      s6_in.d5_p1 = PpW'(s5_ff.d4[2*ChunkW-1:ChunkW]) * PpW'(s5_ff.dur);
      s6_in.d5_p2 = PpW'(s5_ff.d4[3*ChunkW-1:2*ChunkW]) * PpW'(s5_ff.dur);
      s6_in.d5_p3 = PpW'(s5_ff.d4[D4W-1:3*ChunkW]) * PpW'(s5_ff.dur);
   end

   // stage 7: T^5; sign and magnitude of the numerators
   always_comb begin
      s7_in.side = s6_ff.side;
      s7_in.d3   = s6_ff.d3;
      s7_in.d4   = s6_ff.d4;
      s7_in.d5   = DenW'(s6_ff.d5_p0) + (DenW'(s6_ff.d5_p1) << ChunkW)
                 + (DenW'(s6_ff.d5_p2) << (2 * ChunkW))
                 + (DenW'(s6_ff.d5_p3) << (3 * ChunkW));
      s7_in.neg3 = s6_ff.n3[ProdW-1];
      s7_in.neg4 = s6_ff.n4[ProdW-1];
      s7_in.neg5 = s6_ff.n5[ProdW-1];
      s7_in.mag3 = s6_ff.n3[ProdW-1] ? -s6_ff.n3 : s6_ff.n3;
      s7_in.mag4 = s6_ff.n4[ProdW-1] ? -s6_ff.n4 : s6_ff.n4;
      s7_in.mag5 = s6_ff.n5[ProdW-1] ? -s6_ff.n5 : s6_ff.n5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.side.valid <= 1'b0;
         s2_ff.side.valid <= 1'b0;
         s3_ff.side.valid <= 1'b0;
         s4_ff.side.valid <= 1'b0;
         s5_ff.side.valid <= 1'b0;
         s6_ff.side.valid <= 1'b0;
         s7_ff.side.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   // three dividers in lock step; the side line keeps each transaction aligned
   mjq_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div3 (
      .clock   (clock),
      .en      (adv),
      .num_mag (NumW'(s7_ff.mag3) << Sh3),
      .num_neg (s7_ff.neg3),
      .den     (DenW'(s7_ff.d3)),
      .quo     (q3),
      .sat     (sat3)
   );

   mjq_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div4 (
      .clock   (clock),
      .en      (adv),
      .num_mag (NumW'(s7_ff.mag4) << Sh4),
      .num_neg (s7_ff.neg4),
      .den     (DenW'(s7_ff.d4)),
      .quo     (q4),
      .sat     (sat4)
   );

   mjq_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div5 (
      .clock   (clock),
      .en      (adv),
      .num_mag (NumW'(s7_ff.mag5) << Sh5),
      .num_neg (s7_ff.neg5),
      .den     (s7_ff.d5),
      .quo     (q5),
      .sat     (sat5)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DivLat; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         side_ff[0] <= s7_ff.side;
         for (int k = 1; k < DivLat; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // zero duration wins over saturation and drops the divider results
   always_comb begin
      rsp_in.coef0 = side_ff[DivLat-1].c0;
      rsp_in.coef1 = side_ff[DivLat-1].c1;
      rsp_in.coef2 = side_ff[DivLat-1].c2;
      if (side_ff[DivLat-1].zero) begin
         rsp_in.coef3  = '0;
         rsp_in.coef4  = '0;
         rsp_in.coef5  = '0;
         rsp_in.status = STATUS_ZERO_DUR;
      end else begin
         rsp_in.coef3  = q3;
         rsp_in.coef4  = q4;
         rsp_in.coef5  = q5;
         rsp_in.status = (side_ff[DivLat-1].sat || sat3 || sat4 || sat5) ?
                         STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= side_ff[DivLat-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

endmodule
